FILE: sv/jlgs_pkg.sv
// Package for the Jacobi Laplace grid solver.
// Grid geometry, opcodes, sequencer states. No dependencies.
package jlgs_pkg;
	localparam int MAX_ROWS    = 64;
	localparam int MAX_COLS    = 64;
	localparam int VALUE_BITS  = 24;
	localparam int STRIDE      = MAX_COLS + 2;
	localparam int GRID_DEPTH  = (MAX_ROWS + 2) * STRIDE;
	localparam int ADDR_W      = $clog2(GRID_DEPTH);
	localparam int IDX_W       = 7;
	localparam int CNT_W       = 24;
	localparam int CFG_IDX_W   = 2;
	localparam int CFG_DATA_W  = 24;
	localparam int SUM_W       = VALUE_BITS + 2;

	typedef enum logic [1:0] {
		OP_WRITE = 2'd0,
		OP_SOLVE = 2'd1,
		OP_READ  = 2'd2,
		OP_NONE  = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		CFG_ROWS = 2'd0,
		CFG_COLS = 2'd1,
		CFG_TOL  = 2'd2,
		CFG_MAXS = 2'd3
	} cfg_reg_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_READ,
		ST_SWEEP,
		ST_COPY
	} state_t;

	typedef enum logic [2:0] {
		PH_N = 3'd0,
		PH_S = 3'd1,
		PH_W = 3'd2,
		PH_E = 3'd3,
		PH_C = 3'd4,
		PH_WB = 3'd5
	} phase_t;
endpackage

FILE: sv/jlgs_ram.sv
// Generic single-write, single-read synchronous RAM, registered read.
// No dependencies.
module jlgs_ram #(
	parameter int WIDTH = 24,
	parameter int DEPTH = 4356
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

FILE: sv/jacobi_laplace_grid_solver_top.sv
// Top level of the Jacobi Laplace grid solver: command port, config port, sweep sequencer.
// Depends on jlgs_pkg and jlgs_ram.
//
// A write cell answers on done straight after it is taken; a read cell first passes through
// ST_READ for the registered memory read. A solve steps each interior cell of each sweep
// through five reads through the single read port of the source bank, then one write-back,
// then copies the final interior into the other bank, a read and a write per cell, so both
// banks agree again. The grid lives in two banks
// used ping-pong; writes go to both. Config words wait while busy. Each result is
// presented for one cycle on done; the receiver cannot stall and must take it then.
module jacobi_laplace_grid_solver_top (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	output logic                       busy,
	input  logic [1:0]                 opcode,
	input  logic [jlgs_pkg::IDX_W-1:0] row_index,
	input  logic [jlgs_pkg::IDX_W-1:0] col_index,
	input  logic [jlgs_pkg::VALUE_BITS-1:0] cell_value,
	input  logic                       cfg_valid,
	output logic                       cfg_ready,
	input  logic [jlgs_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [jlgs_pkg::CFG_DATA_W-1:0] cfg_data,
	output logic                       done,
	output logic [jlgs_pkg::VALUE_BITS-1:0] read_value,
	output logic [jlgs_pkg::CNT_W-1:0]      sweeps_done,
	output logic [jlgs_pkg::VALUE_BITS-1:0] final_change,
	output logic                       converged,
	output logic                       index_error
);
	import jlgs_pkg::*;

	state_t state_q, state_d;
	logic [IDX_W-1:0] rows_q, cols_q, rows_eff, cols_eff;
	logic [CNT_W-1:0] tol_q, maxs_q, limit;
	logic sel_q;
	logic [2:0] phase_q;
	logic [IDX_W-1:0] r_q, c_q;
	logic [ADDR_W-1:0] k_q, raddr, waddr, host_addr;
	logic [SUM_W-1:0] sum_q;
	logic [VALUE_BITS-1:0] worst_q, rdata_a, rdata_b, rd, nv, diff, worst_n, wdata;
	logic [CNT_W-1:0] count_q;
	logic accept, host_wr, sweep_wr, copy_wr, oob, last_cell, more;

	assign cfg_ready = !busy;
	assign busy = (state_q != ST_IDLE);
	assign accept = start && !busy;

	always_comb begin
		rows_eff = (rows_q == '0) ? IDX_W'(1)
			: (rows_q > IDX_W'(MAX_ROWS)) ? IDX_W'(MAX_ROWS) : rows_q;
		cols_eff = (cols_q == '0) ? IDX_W'(1)
			: (cols_q > IDX_W'(MAX_COLS)) ? IDX_W'(MAX_COLS) : cols_q;
		limit = (maxs_q == '0) ? CNT_W'(1) : maxs_q;
	end

	assign oob = ({1'b0, row_index} > ({1'b0, rows_eff} + 8'd1))
		|| ({1'b0, col_index} > ({1'b0, cols_eff} + 8'd1));
	assign host_addr = ADDR_W'(ADDR_W'(row_index) * ADDR_W'(STRIDE) + ADDR_W'(col_index));
	assign host_wr = accept && (op_t'(opcode) == OP_WRITE) && !oob;

	assign rd = sel_q ? rdata_b : rdata_a;
	assign nv = sum_q[SUM_W-1:2];
	assign diff = (nv >= rd) ? (nv - rd) : (rd - nv);
	assign worst_n = (diff > worst_q) ? diff : worst_q;
	assign sweep_wr = (state_q == ST_SWEEP) && (phase_q == PH_WB);
	assign copy_wr = (state_q == ST_COPY) && (phase_q == PH_WB);
	assign last_cell = (r_q == rows_eff) && (c_q == cols_eff);
	assign more = (worst_n > tol_q) && ({1'b0, count_q} + 25'd1 < {1'b0, limit});

	always_comb begin
		if (state_q == ST_SWEEP) begin
			unique case (phase_q)
				PH_N:    raddr = k_q - ADDR_W'(STRIDE);
				PH_S:    raddr = k_q + ADDR_W'(STRIDE);
				PH_W:    raddr = k_q - ADDR_W'(1);
				PH_E:    raddr = k_q + ADDR_W'(1);
				default: raddr = k_q;
			endcase
		end else if (state_q == ST_COPY) begin
			raddr = k_q;
		end else begin
			raddr = host_addr;
		end
	end

	assign waddr = (sweep_wr || copy_wr) ? k_q : host_addr;
	assign wdata = sweep_wr ? nv : copy_wr ? rd : cell_value;

	jlgs_ram #(.WIDTH(VALUE_BITS), .DEPTH(GRID_DEPTH)) u_bank_a (
		.clk(clk), .we(host_wr || ((sweep_wr || copy_wr) && sel_q)), .waddr(waddr),
		.wdata(wdata), .raddr(raddr), .rdata(rdata_a)
	);
	jlgs_ram #(.WIDTH(VALUE_BITS), .DEPTH(GRID_DEPTH)) u_bank_b (
		.clk(clk), .we(host_wr || ((sweep_wr || copy_wr) && !sel_q)), .waddr(waddr),
		.wdata(wdata), .raddr(raddr), .rdata(rdata_b)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept && op_t'(opcode) == OP_SOLVE) begin
					state_d = ST_SWEEP;
				end else if (accept && op_t'(opcode) == OP_READ && !oob) begin
					state_d = ST_READ;
				end
			end
			ST_READ:  state_d = ST_IDLE;
			ST_SWEEP: begin
				if (sweep_wr && last_cell && !more) begin
					state_d = ST_COPY;
				end
			end
			ST_COPY: begin
				if (copy_wr && last_cell) begin
					state_d = ST_IDLE;
				end
			end
			default:  state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rows_q  <= IDX_W'(64);
			cols_q  <= IDX_W'(64);
			tol_q   <= CNT_W'(655);
			maxs_q  <= CNT_W'(10000000);
			sel_q   <= 1'b0;
			phase_q <= '0;
			done    <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				unique case (cfg_reg_t'(cfg_index))
					CFG_ROWS: rows_q <= cfg_data[IDX_W-1:0];
					CFG_COLS: cols_q <= cfg_data[IDX_W-1:0];
					CFG_TOL:  tol_q  <= cfg_data;
					CFG_MAXS: maxs_q <= cfg_data;
				endcase
			end
			done <= 1'b0;
			if (state_q == ST_SWEEP) begin
				if (sweep_wr && last_cell && !more) begin
					phase_q <= 3'(PH_C);
				end else begin
					phase_q <= (phase_q == PH_WB) ? 3'(PH_N) : phase_q + 3'd1;
				end
				if (sweep_wr && last_cell) begin
					sel_q <= !sel_q;
				end
			end else if (state_q == ST_COPY) begin
				phase_q <= (phase_q == PH_WB) ? 3'(PH_C) : 3'(PH_WB);
				if (copy_wr && last_cell) begin
					done <= 1'b1;
				end
			end else if (accept) begin
				phase_q <= '0;
				if (op_t'(opcode) != OP_SOLVE && !(op_t'(opcode) == OP_READ && !oob)) begin
					done <= 1'b1;
				end
			end else if (state_q == ST_READ) begin
				done <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			r_q <= IDX_W'(1);
			c_q <= IDX_W'(1);
			k_q <= ADDR_W'(STRIDE + 1);
			worst_q <= '0;
			count_q <= '0;
			read_value   <= '0;
			sweeps_done  <= '0;
			final_change <= '0;
			converged    <= 1'b0;
			index_error  <= (op_t'(opcode) == OP_WRITE || op_t'(opcode) == OP_READ) && oob;
		end
		if (state_q == ST_READ) begin
			read_value <= rd;
		end
		if (state_q == ST_SWEEP) begin
			unique case (phase_q)
				PH_N:  ;
				PH_S:  sum_q <= SUM_W'(rd);
				PH_W, PH_E, PH_C: sum_q <= sum_q + SUM_W'(rd);
				default: begin
					if (last_cell) begin
						count_q <= count_q + CNT_W'(1);
						r_q <= IDX_W'(1);
						c_q <= IDX_W'(1);
						k_q <= ADDR_W'(STRIDE + 1);
						worst_q <= '0;
						sweeps_done  <= count_q + CNT_W'(1);
						final_change <= worst_n;
						converged    <= (worst_n <= tol_q);
					end else if (c_q == cols_eff) begin
						worst_q <= worst_n;
						r_q <= r_q + IDX_W'(1);
						c_q <= IDX_W'(1);
						k_q <= k_q + ADDR_W'(STRIDE + 1) - ADDR_W'(cols_eff);
					end else begin
						worst_q <= worst_n;
						c_q <= c_q + IDX_W'(1);
						k_q <= k_q + ADDR_W'(1);
					end
				end
			endcase
		end
		if (copy_wr) begin
			if (c_q == cols_eff) begin
				r_q <= r_q + IDX_W'(1);
				c_q <= IDX_W'(1);
				k_q <= k_q + ADDR_W'(STRIDE + 1) - ADDR_W'(cols_eff);
			end else begin
				c_q <= c_q + IDX_W'(1);
				k_q <= k_q + ADDR_W'(1);
			end
		end
	end

	a_read_done: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_READ) |=> done) else $error("read result missing");
	a_write_done: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && opcode == OP_WRITE) |=> (done && !busy)) else $error("write result missing");
	a_no_mix: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !(converged && index_error)) else $error("solve and index flags together");
	a_phase: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SWEEP) |-> (phase_q <= 3'(PH_WB))) else $error("phase out of range");
endmodule

FILE: tb/tb_jacobi_laplace_grid_solver_top.sv
// Testbench for jacobi_laplace_grid_solver_top: a directed table, then random phases of
// cell writes, reads, solves and no-ops, each checked against an in-bench grid predictor.
// Depends on jlgs_pkg and the solver RTL.
module tb_jacobi_laplace_grid_solver_top;
	timeunit 1ns;
	timeprecision 1ps;
	import jlgs_pkg::*;

	localparam int LIMIT = 5_000_000;
	localparam int GDIM  = MAX_ROWS + 2;

	typedef logic [VALUE_BITS-1:0] val_t;

	typedef struct packed {
		val_t             rd;
		logic [CNT_W-1:0] sw;
		val_t             fc;
		logic             cv;
		logic             err;
	} res_t;

	typedef struct {
		op_t  op;
		int   r;
		int   c;
		val_t v;
		bit   typed;
		res_t e;
	} dir_t;

	logic clk, arst_n, start, busy, cfg_valid, cfg_ready, done;
	logic [1:0] opcode;
	logic [IDX_W-1:0] row_index, col_index;
	val_t cell_value;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;
	val_t read_value, final_change;
	logic [CNT_W-1:0] sweeps_done;
	logic converged, index_error;

	jacobi_laplace_grid_solver_top i_dut (.*);

	val_t old_grid [GDIM*GDIM];
	val_t new_grid [GDIM*GDIM];
	logic [6:0]  m_rows = 7'd64, m_cols = 7'd64;
	logic [23:0] m_tol = 24'd655, m_maxs = 24'd10000000;

	res_t result_q[$];
	int   n_words, n_cfg, cycles, errors;
	bit   typed_pend;
	res_t typed_res;
	bit   idle_en;

	function automatic int eff_dim(logic [6:0] d, int mx);
		if (d == 0) return 1;
		if (d > mx) return mx;
		return d;
	endfunction

	function automatic val_t run_sweep(int nr, int nc);
		logic [SUM_W-1:0] s;
		val_t d, worst;
		int k;
		worst = '0;
		for (int r = 1; r <= nr; r++)
			for (int c = 1; c <= nc; c++) begin
				k = r*GDIM + c;
				s = SUM_W'(old_grid[k-GDIM]) + old_grid[k+GDIM] + old_grid[k-1] + old_grid[k+1];
				new_grid[k] = val_t'(s >> 2);
			end
		for (int r = 1; r <= nr; r++)
			for (int c = 1; c <= nc; c++) begin
				k = r*GDIM + c;
				d = (new_grid[k] >= old_grid[k]) ? new_grid[k] - old_grid[k]
				                                 : old_grid[k] - new_grid[k];
				if (d > worst) worst = d;
				old_grid[k] = new_grid[k];
			end
		return worst;
	endfunction

	function automatic res_t grid_predict(op_t op, int r, int c, val_t v);
		res_t o;
		int nr, nc, lim;
		val_t ch;
		o = '0;
		nr = eff_dim(m_rows, MAX_ROWS);
		nc = eff_dim(m_cols, MAX_COLS);
		if (op == OP_WRITE || op == OP_READ) begin
			if (r > nr+1 || c > nc+1) o.err = 1'b1;
			else if (op == OP_WRITE) begin
				old_grid[r*GDIM+c] = v;
				new_grid[r*GDIM+c] = v;
			end else o.rd = old_grid[r*GDIM+c];
		end else if (op == OP_SOLVE) begin
			lim = (m_maxs == 0) ? 1 : m_maxs;
			do begin
				ch = run_sweep(nr, nc);
				o.sw++;
			end while (ch > m_tol && o.sw < lim);
			o.fc = ch;
			o.cv = (ch <= m_tol);
		end
		return o;
	endfunction

	task automatic check_field(string nm, logic [31:0] e, logic [31:0] a);
		if (e !== a) begin
			$display("%0t %s mismatch: expected %h actual %h", $time, nm, e, a);
			errors++;
		end
	endtask

	initial begin
		clk = 0;
		forever #10 clk = ~clk;
	end

	always @(posedge clk) begin
		res_t e;
		cycles++;
		if (cycles > LIMIT) begin
			$display("tb: failure");
			$finish;
		end
		if (arst_n) begin
			if (done) begin
				if (result_q.size() == 0) begin
					$display("%0t unexpected word: read %h sweeps %h change %h", $time,
						read_value, sweeps_done, final_change);
					errors++;
				end else begin
					e = result_q.pop_front();
					check_field("read_value", e.rd, read_value);
					check_field("sweeps_done", e.sw, sweeps_done);
					check_field("final_change", e.fc, final_change);
					check_field("converged", e.cv, converged);
					check_field("index_error", e.err, index_error);
				end
			end
			if (cfg_valid && cfg_ready) begin
				case (cfg_reg_t'(cfg_index))
					CFG_ROWS: m_rows = cfg_data[6:0];
					CFG_COLS: m_cols = cfg_data[6:0];
					CFG_TOL:  m_tol  = cfg_data;
					CFG_MAXS: m_maxs = cfg_data;
				endcase
				n_cfg++;
			end
			if (start && !busy) begin
				e = grid_predict(op_t'(opcode), row_index, col_index, cell_value);
				result_q.push_back(typed_pend ? typed_res : e);
				n_words++;
			end
		end
	end

	task automatic issue(op_t op, int r, int c, val_t v, bit typed = 0, res_t te = '0);
		int target;
		if (idle_en && $urandom_range(0, 5) == 0) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 4)) @(negedge clk);
		end
		start <= 1'b1;
		opcode <= op;
		row_index <= IDX_W'(r);
		col_index <= IDX_W'(c);
		cell_value <= v;
		typed_pend = typed;
		typed_res = te;
		target = n_words + 1;
		do @(negedge clk); while (n_words < target);
		typed_pend = 0;
	endtask

	task automatic drain();
		start <= 1'b0;
		while (result_q.size() != 0) @(negedge clk);
		repeat (8) @(negedge clk);
	endtask

	task automatic cfg_write(cfg_reg_t idx, logic [23:0] d);
		int target;
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= d;
		target = n_cfg + 1;
		do @(negedge clk); while (n_cfg < target);
		cfg_valid <= 1'b0;
		@(negedge clk);
	endtask

	task automatic set_config(logic [6:0] r, logic [6:0] c, logic [23:0] t, logic [23:0] m);
		drain();
		cfg_write(CFG_ROWS, r);
		cfg_write(CFG_COLS, c);
		cfg_write(CFG_TOL, t);
		cfg_write(CFG_MAXS, m);
	endtask

	function automatic dir_t mk(op_t op, int r, int c, val_t v, bit typed = 0,
		val_t rd = 0, bit err = 0);
		dir_t d;
		d.op = op; d.r = r; d.c = c; d.v = v; d.typed = typed;
		d.e = '0;
		d.e.rd = rd;
		d.e.err = err;
		return d;
	endfunction

	initial begin
		dir_t tbl[$];
		op_t op;
		int nr, nc, r, c, pick, n_left;
		logic [6:0] pr, pc;
		logic [23:0] pt, pm;

		arst_n = 0; start = 0; opcode = OP_WRITE; row_index = 0; col_index = 0;
		cell_value = 0; cfg_valid = 0; cfg_index = CFG_ROWS; cfg_data = 0;
		errors = 0; idle_en = 1;
		repeat (10) @(negedge clk);
		arst_n = 1;
		@(negedge clk);

		// load every cell that a later read or sweep can reach
		for (int i = 0; i < GDIM; i++)
			for (int j = 0; j < GDIM; j++)
				if (j <= 2 || i <= 2 || (i <= 5 && j <= 5))
					issue(OP_WRITE, i, j, val_t'($urandom()));

		set_config(7'd2, 7'd2, 24'd0, 24'd3);
		tbl.push_back(mk(OP_WRITE, 0, 0, 24'h0));
		tbl.push_back(mk(OP_READ, 0, 0, 0, 1, 24'h0));
		tbl.push_back(mk(OP_WRITE, 3, 3, 24'hFFFFFF));
		tbl.push_back(mk(OP_READ, 3, 3, 0, 1, 24'hFFFFFF));
		tbl.push_back(mk(OP_WRITE, 1, 1, 24'hFFFFFF));
		tbl.push_back(mk(OP_WRITE, 1, 2, 24'h000000));
		tbl.push_back(mk(OP_WRITE, 2, 1, 24'hAAAAAA));
		tbl.push_back(mk(OP_WRITE, 2, 2, 24'h555555));
		tbl.push_back(mk(OP_WRITE, 4, 0, 24'h123456, 1, 0, 1));
		tbl.push_back(mk(OP_READ, 0, 4, 0, 1, 0, 1));
		tbl.push_back(mk(OP_READ, 127, 127, 0, 1, 0, 1));
		tbl.push_back(mk(OP_WRITE, 127, 0, 24'hFFFFFF, 1, 0, 1));
		tbl.push_back(mk(OP_NONE, 127, 127, 24'hFFFFFF, 1));
		tbl.push_back(mk(OP_SOLVE, 127, 127, 24'hFFFFFF));
		tbl.push_back(mk(OP_READ, 1, 1, 0));
		tbl.push_back(mk(OP_READ, 2, 2, 0));
		for (int k = 1; k <= 2; k++) begin
			tbl.push_back(mk(OP_WRITE, 0, k, 24'hFFFFFF));
			tbl.push_back(mk(OP_WRITE, 3, k, 24'hFFFFFF));
		end
		tbl.push_back(mk(OP_SOLVE, 0, 0, 0));
		tbl.push_back(mk(OP_READ, 1, 2, 0));
		foreach (tbl[i]) begin
			res_t te;
			te = '0;
			te.rd = tbl[i].e.rd;
			te.err = tbl[i].e.err;
			issue(tbl[i].op, tbl[i].r, tbl[i].c, tbl[i].v, tbl[i].typed, te);
		end

		n_left = 1030;
		for (int ph = 0; n_left > 0; ph++) begin
			case (ph)
				0: begin pr = 7'd127; pc = 7'd1; pt = 24'd0; pm = 24'd0; end
				1: begin pr = 7'd0; pc = 7'd0; pt = 24'hFFFFFF; pm = 24'hFFFFFF; end
				2: begin pr = 7'd1; pc = 7'd127; pt = 24'd0; pm = 24'd2; end
				default: begin
					pr = 7'($urandom_range(1, 4));
					pc = 7'($urandom_range(1, 4));
					pt = $urandom_range(0, 1) ? 24'($urandom_range(0, 4000)) : 24'($urandom());
					pm = 24'($urandom_range(1, 10));
				end
			endcase
			set_config(pr, pc, pt, pm);
			nr = eff_dim(pr, MAX_ROWS);
			nc = eff_dim(pc, MAX_COLS);
			for (int i = 0; i < 50 && n_left > 0; i++, n_left--) begin
				idle_en = (n_left > 150);
				pick = $urandom_range(0, 99);
				op = pick < 45 ? OP_WRITE : pick < 88 ? OP_READ : pick < 94 ? OP_SOLVE : OP_NONE;
				if ($urandom_range(0, 99) < 85) begin
					r = $urandom_range(0, nr+1);
					c = $urandom_range(0, nc+1);
				end else begin
					r = $urandom_range(0, 127);
					c = $urandom_range(0, 127);
				end
				issue(op, r, c, val_t'($urandom()));
			end
		end

		drain();
		repeat (20) @(negedge clk);
		if (errors == 0) $display("tb: success");
		else $display("tb: failure");
		$finish;
	end
endmodule
